// File: sv/mhpq_pkg.sv
// Shared types and constants for the min-heap priority queue.
// No dependencies; the interfaces, the comparator and the core refer to this package.
package mhpq_pkg;

   localparam int VALUE_W  = 32;
   localparam int OPCODE_W = 2;
   localparam int COUNT_W  = 11;
   localparam int STATUS_W = 2;

   typedef enum logic [OPCODE_W-1:0] {
      OP_PUSH = 2'd0,
      OP_POP  = 2'd1,
      OP_PEEK = 2'd2
   } opcode_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK        = 2'd0,
      ST_OVERFLOW  = 2'd1,
      ST_UNDERFLOW = 2'd2
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_UP_RD,
      S_UP_CMP,
      S_DN_LAST,
      S_DN_LEFT,
      S_DN_RIGHT,
      S_DN_PICK,
      S_DN_CMP,
      S_DONE
   } state_type;

endpackage

// File: sv/mhpq_if.sv
// Request and response channel interfaces of the min-heap priority queue.
// Depends on mhpq_pkg for the payload widths.
interface mhpq_req_if;
   logic                                valid;
   logic                                ready;
   logic [mhpq_pkg::OPCODE_W-1:0]       opcode;
   logic signed [mhpq_pkg::VALUE_W-1:0] value;

   modport source (output valid, output opcode, output value, input ready);
   modport sink   (input valid, input opcode, input value, output ready);
endinterface

interface mhpq_rsp_if;
   logic                                valid;
   logic                                ready;
   logic signed [mhpq_pkg::VALUE_W-1:0] top_value;
   logic [mhpq_pkg::COUNT_W-1:0]        count;
   logic                                is_empty;
   logic [mhpq_pkg::STATUS_W-1:0]       status;

   modport source (output valid, output top_value, output count, output is_empty,
                   output status, input ready);
   modport sink   (input valid, input top_value, input count, input is_empty,
                   input status, output ready);
endinterface

// File: sv/mhpq_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mhpq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: sv/mhpq_key_cmp.sv
// Shared signed key comparator used by every sift comparison.
// Depends on mhpq_pkg for the key width.
module mhpq_key_cmp (
   input  logic signed [mhpq_pkg::VALUE_W-1:0] lhs,
   input  logic signed [mhpq_pkg::VALUE_W-1:0] rhs,
   output logic                                less
);

   // strict signed less-than; equal keys do not move
   assign less = (lhs < rhs);

endmodule

// File: sv/min_heap_priority_queue_core.sv
// Min-heap priority queue of signed 32-bit keys.
// Requests arrive on req_chan (opcode, value): push inserts value, pop removes
// the minimum, peek (and the unused opcode) changes nothing. Each request
// yields exactly one response on rsp_chan: the minimum after the request
// (zero when empty), the entry count, an empty flag and a status (overflow on
// a push into a full heap, underflow on a pop of an empty heap).
// One request is worked at a time; req_chan.ready is high only while idle.
// Work per request, from accept to response valid:
//   peek, rejected request or pop to empty: straight to the response
//   push: a parent read and compare for each level climbed, then the key
//         is written where it settles
//   pop:  the last entry is read, then per level a read of each child present,
//         a pick and a compare, until the key settles
// These steps are bounded by the single RAM read port (one key per cycle,
// registered read data) and the single shared key comparator.
// The response sits in an output register; a new request is accepted while it
// waits, and only the finish of that next request waits for the receiver.
// Reset (synchronous, active high) empties the heap; the store is not cleared.
module min_heap_priority_queue_core #(
   parameter int CAPACITY = 1024
) (
   input  logic            clock,
   input  logic            reset,
   mhpq_req_if.sink        req_chan,
   mhpq_rsp_if.source      rsp_chan
);

   localparam int AW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int XW = AW + 2;

   typedef logic signed [mhpq_pkg::VALUE_W-1:0] key_type;

   mhpq_pkg::state_type  state_ff, state_in;
   logic [CW-1:0]        count_ff, count_in;
   logic [AW-1:0]        pos_ff, pos_in;
   key_type              key_ff, key_in;
   key_type              best_ff, best_in;
   logic [AW-1:0]        best_idx_ff, best_idx_in;
   key_type              top_ff, top_in;
   mhpq_pkg::status_type status_ff, status_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   key_type              rsp_top_ff, rsp_top_in;
   logic [mhpq_pkg::COUNT_W-1:0] rsp_count_ff, rsp_count_in;
   logic                 rsp_empty_ff, rsp_empty_in;
   mhpq_pkg::status_type rsp_status_ff, rsp_status_in;

   logic                 mem_we;
   logic [AW-1:0]        mem_waddr;
   key_type              mem_wdata;
   logic [AW-1:0]        mem_raddr;
   key_type              rd_data;

   key_type              cmp_lhs, cmp_rhs;
   logic                 cmp_less;

   logic                 req_acc;
   logic [CW-1:0]        cnt_dec;
   logic [AW-1:0]        parent_idx;
   logic [XW-1:0]        left_x, right_x, n_x;

   // heap store
   mhpq_ram #(
      .WIDTH (mhpq_pkg::VALUE_W),
      .DEPTH (CAPACITY)
   ) u_store (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_addr (mem_raddr),
      .rd_data (rd_data)
   );

   // shared comparator
   mhpq_key_cmp u_cmp (
      .lhs  (cmp_lhs),
      .rhs  (cmp_rhs),
      .less (cmp_less)
   );

   // index arithmetic
   assign req_acc    = req_chan.valid && req_chan.ready;
   assign cnt_dec    = count_ff - CW'(1);
   assign parent_idx = AW'((pos_ff - AW'(1)) >> 1);
   assign left_x     = XW'({pos_ff, 1'b1});
   assign right_x    = left_x + XW'(1);
   assign n_x        = XW'(count_ff);

   // state and control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mhpq_pkg::S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // working and response payload registers
   always_ff @(posedge clock) begin
      pos_ff        <= pos_in;
      key_ff        <= key_in;
      best_ff       <= best_in;
      best_idx_ff   <= best_idx_in;
      top_ff        <= top_in;
      status_ff     <= status_in;
      rsp_top_ff    <= rsp_top_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_empty_ff  <= rsp_empty_in;
      rsp_status_ff <= rsp_status_in;
   end

   // sequencer: next state, memory and comparator control
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      pos_in        = pos_ff;
      key_in        = key_ff;
      best_in       = best_ff;
      best_idx_in   = best_idx_ff;
      status_in     = status_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_top_in    = rsp_top_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_empty_in  = rsp_empty_ff;
      rsp_status_in = rsp_status_ff;
      mem_we        = 1'b0;
      mem_waddr     = pos_ff;
      mem_wdata     = key_ff;
      mem_raddr     = '0;
      cmp_lhs       = key_ff;
      cmp_rhs       = rd_data;
      req_chan.ready = 1'b0;

      // drop the response once taken
      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         mhpq_pkg::S_IDLE: begin
            req_chan.ready = 1'b1;
            if (req_acc) begin
               status_in = mhpq_pkg::ST_OK;
               state_in  = mhpq_pkg::S_DONE;
               unique case (req_chan.opcode)
                  mhpq_pkg::OP_PUSH: begin
                     if (count_ff == CW'(CAPACITY)) begin
                        status_in = mhpq_pkg::ST_OVERFLOW;
                     end else begin
                        key_in   = req_chan.value;
                        pos_in   = count_ff[AW-1:0];
                        count_in = count_ff + CW'(1);
                        state_in = mhpq_pkg::S_UP_RD;
                     end
                  end
                  mhpq_pkg::OP_POP: begin
                     if (count_ff == '0) begin
                        status_in = mhpq_pkg::ST_UNDERFLOW;
                     end else begin
                        count_in = cnt_dec;
                        if (cnt_dec != '0) begin
                           mem_raddr = cnt_dec[AW-1:0];
                           state_in  = mhpq_pkg::S_DN_LAST;
                        end
                     end
                  end
                  default: begin
                     state_in = mhpq_pkg::S_DONE;
                  end
               endcase
            end
         end

         // sift up: fetch the parent of the hole, or settle the key at the root
         mhpq_pkg::S_UP_RD: begin
            if (pos_ff == '0) begin
               mem_we   = 1'b1;
               state_in = mhpq_pkg::S_DONE;
            end else begin
               mem_raddr = parent_idx;
               state_in  = mhpq_pkg::S_UP_CMP;
            end
         end

         // sift up: move the parent down or settle the key
         mhpq_pkg::S_UP_CMP: begin
            mem_we = 1'b1;
            if (cmp_less) begin
               mem_wdata = rd_data;
               pos_in    = parent_idx;
               state_in  = mhpq_pkg::S_UP_RD;
            end else begin
               state_in = mhpq_pkg::S_DONE;
            end
         end

         // sift down: capture the last entry as the key to place
         mhpq_pkg::S_DN_LAST: begin
            key_in   = rd_data;
            pos_in   = '0;
            state_in = mhpq_pkg::S_DN_LEFT;
         end

         mhpq_pkg::S_DN_LEFT: begin
            if (left_x < n_x) begin
               mem_raddr = left_x[AW-1:0];
               state_in  = mhpq_pkg::S_DN_RIGHT;
            end else begin
               mem_we   = 1'b1;
               state_in = mhpq_pkg::S_DONE;
            end
         end

         // hold the left child, fetch the right one if present
         mhpq_pkg::S_DN_RIGHT: begin
            best_in     = rd_data;
            best_idx_in = left_x[AW-1:0];
            if (right_x < n_x) begin
               mem_raddr = right_x[AW-1:0];
               state_in  = mhpq_pkg::S_DN_PICK;
            end else begin
               state_in = mhpq_pkg::S_DN_CMP;
            end
         end

         // right child wins only when strictly smaller
         mhpq_pkg::S_DN_PICK: begin
            cmp_lhs = rd_data;
            cmp_rhs = best_ff;
            if (cmp_less) begin
               best_in     = rd_data;
               best_idx_in = right_x[AW-1:0];
            end
            state_in = mhpq_pkg::S_DN_CMP;
         end

         // move the smaller child up or settle the key
         mhpq_pkg::S_DN_CMP: begin
            cmp_lhs = best_ff;
            cmp_rhs = key_ff;
            mem_we  = 1'b1;
            if (cmp_less) begin
               mem_wdata = best_ff;
               pos_in    = best_idx_ff;
               state_in  = mhpq_pkg::S_DN_LEFT;
            end else begin
               state_in = mhpq_pkg::S_DONE;
            end
         end

         // load the response register when it is free
         mhpq_pkg::S_DONE: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_top_in    = (count_ff == '0) ? key_type'(0) : top_ff;
               rsp_count_in  = mhpq_pkg::COUNT_W'(count_ff);
               rsp_empty_in  = (count_ff == '0);
               rsp_status_in = status_ff;
               state_in      = mhpq_pkg::S_IDLE;
            end
         end

         default: begin
            state_in = mhpq_pkg::S_IDLE;
         end
      endcase
   end

   // mirror the root entry
   always_comb begin
      top_in = top_ff;
      if (mem_we && (mem_waddr == '0)) begin
         top_in = mem_wdata;
      end
   end

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.top_value = rsp_top_ff;
   assign rsp_chan.count     = rsp_count_ff;
   assign rsp_chan.is_empty  = rsp_empty_ff;
   assign rsp_chan.status    = rsp_status_ff;

   // the entry count never passes the capacity
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(CAPACITY))
      else $error("entry count above capacity");

   // every store write lands inside the live part of the heap
   a_write_in_range: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> (CW'(mem_waddr) < count_ff))
      else $error("store write beyond entry count");

   // an accepted pop on a non-empty heap drops the count by one
   a_pop_count: assert property (@(posedge clock) disable iff (reset)
      (req_acc && (req_chan.opcode == mhpq_pkg::OP_POP) && (count_ff != '0))
      |=> (count_ff == $past(cnt_dec)))
      else $error("pop did not decrement the count");

   // the store is written only while sifting
   a_write_when_sifting: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> ((state_ff == mhpq_pkg::S_UP_RD) || (state_ff == mhpq_pkg::S_UP_CMP) ||
                  (state_ff == mhpq_pkg::S_DN_LEFT) || (state_ff == mhpq_pkg::S_DN_CMP)))
      else $error("store write outside a sift");

endmodule
